// File: hdl/sdspi_pkg.sv
// Shared types, codes and frame constants for the SD SPI command and response engine.
package sdspi_pkg;

    // Request selectors carried on the input tuser field.
    localparam logic [1:0] CMD_ISSUE = 2'd0;
    localparam logic [1:0] CMD_RESP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ILLEGAL = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_LINK    = 3'd3;
    localparam logic [2:0] ST_RESP    = 3'd4;
    localparam logic [2:0] ST_TOKEN   = 3'd5;

    // Bytes on the serial link.
    localparam logic [1:0] FRAME_START = 2'b01;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_OTHER   = 8'h01;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;
    localparam logic [7:0] DATA_TOKEN  = 8'hFE;
    localparam logic [5:0] IDX_CMD0    = 6'd0;
    localparam logic [5:0] IDX_CMD8    = 6'd8;
    localparam logic [5:0] IDX_READ    = 6'd17;

    // Length limits and reset value of the poll limit.
    localparam logic [9:0]  MAX_BLOCK_BYTES = 10'd512;
    localparam logic [15:0] POLL_LIMIT_RST  = 16'd256;

    // A command frame is six bytes long.
    localparam int FRAME_BEATS = 6;
    localparam int BEAT_W      = $clog2(FRAME_BEATS);
    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(FRAME_BEATS - 1);

    // Job queue depth.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One job from the front: either a single result or a whole command frame.
    typedef struct packed {
        logic        is_frame;
        logic [5:0]  frame_idx;
        logic [31:0] frame_arg;
        logic        frame_status;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        status_valid;
        logic [2:0]  status;
    } job_t;

    // Queue fill status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: hdl/sdspi_front.sv
// Front part: accepts requests and card bytes, runs the protocol phases and issues jobs.
module sdspi_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  sdspi_pkg::q_status_t q_status,
    output logic                push,
    output sdspi_pkg::job_t     push_job
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RESP_POLL = 4'd1;
    localparam logic [3:0] PH_RESP_EXTRA = 4'd2;
    localparam logic [3:0] PH_RD_FLUSH  = 4'd3;
    localparam logic [3:0] PH_RD_R1     = 4'd4;
    localparam logic [3:0] PH_RD_TOKEN  = 4'd5;
    localparam logic [3:0] PH_RD_DATA   = 4'd6;
    localparam logic [3:0] PH_RD_CRC1   = 4'd7;
    localparam logic [3:0] PH_RD_CRC2   = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] poll_count_reg, poll_count_next;
    logic [9:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] poll_limit_reg;

    logic        accept;
    logic [7:0]  cmd_index;
    logic [31:0] argument;
    logic [9:0]  byte_count;
    logic [7:0]  rx_byte;
    logic        link_error;
    logic [9:0]  cnt_eff;
    logic [9:0]  blk_len;
    logic [9:0]  bytes_dec;
    logic [15:0] limit_eff;
    logic        limit_hit;
    logic [15:0] poll_inc;

    // Builds a single-result job; a field whose valid bit is low is zero.
    function automatic sdspi_pkg::job_t single(input logic txv, input logic [7:0] tx,
                                               input logic dv, input logic [7:0] d,
                                               input logic sv, input logic [2:0] st);
        sdspi_pkg::job_t j;
        j              = '0;
        j.tx_valid     = txv;
        j.tx_byte      = txv ? tx : 8'h00;
        j.data_valid   = dv;
        j.data_byte    = dv ? d : 8'h00;
        j.status_valid = sv;
        j.status       = sv ? st : sdspi_pkg::ST_OK;
        return j;
    endfunction

    // Builds a command frame job.
    function automatic sdspi_pkg::job_t frame(input logic [5:0] idx, input logic [31:0] arg,
                                              input logic with_status);
        sdspi_pkg::job_t j;
        j              = '0;
        j.is_frame     = 1'b1;
        j.frame_idx    = idx;
        j.frame_arg    = arg;
        j.frame_status = with_status;
        return j;
    endfunction

    // Unpack the input item.
    assign cmd_index  = s_tdata[7:0];
    assign argument   = s_tdata[39:8];
    assign byte_count = s_tdata[49:40];
    assign rx_byte    = s_tdata[57:50];
    assign link_error = s_tdata[58];

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // Length, limit and counter helpers.
    assign cnt_eff   = (byte_count == 10'd0) ? 10'd1 : byte_count;
    assign blk_len   = (cnt_eff > sdspi_pkg::MAX_BLOCK_BYTES) ? sdspi_pkg::MAX_BLOCK_BYTES
                                                              : cnt_eff;
    assign bytes_dec = (bytes_left_reg == 10'd0) ? 10'd0 : bytes_left_reg - 10'd1;
    assign limit_eff = (poll_limit_reg == 16'd0) ? 16'd1 : poll_limit_reg;
    assign limit_hit = poll_count_reg >= limit_eff;
    assign poll_inc  = poll_count_reg + 16'd1;

    // Phase sequencing and job selection for each accepted item.
    always_comb begin
        phase_next      = phase_reg;
        poll_count_next = poll_count_reg;
        bytes_left_next = bytes_left_reg;
        push            = 1'b0;
        push_job        = '0;
        if (accept) begin
            case (s_tuser)
                sdspi_pkg::CMD_ISSUE: begin
                    phase_next = PH_IDLE;
                    push       = 1'b1;
                    if (cmd_index[7:6] != 2'b00) begin
                        push_job = single(1'b0, 8'h00, 1'b0, 8'h00, 1'b1,
                                          sdspi_pkg::ST_ILLEGAL);
                    end else begin
                        push_job = frame(cmd_index[5:0], argument, 1'b1);
                    end
                end
                sdspi_pkg::CMD_RESP: begin
                    phase_next      = PH_RESP_POLL;
                    bytes_left_next = cnt_eff;
                    poll_count_next = 16'd1;
                    push            = 1'b1;
                    push_job        = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00, 1'b0,
                                             sdspi_pkg::ST_OK);
                end
                sdspi_pkg::CMD_READ: begin
                    phase_next      = PH_RD_FLUSH;
                    bytes_left_next = blk_len;
                    poll_count_next = 16'd0;
                    push            = 1'b1;
                    push_job        = frame(sdspi_pkg::IDX_READ, argument, 1'b0);
                end
                default: begin
                    // A byte clocked back from the card.
                    case (phase_reg)
                        PH_RESP_POLL: begin
                            push = 1'b1;
                            if (rx_byte == sdspi_pkg::FILL_BYTE) begin
                                if (limit_hit) begin
                                    phase_next = PH_IDLE;
                                    push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                        8'h00, 1'b1, sdspi_pkg::ST_TIMEOUT);
                                end else begin
                                    poll_count_next = poll_inc;
                                    push_job        = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                             8'h00, 1'b0, sdspi_pkg::ST_OK);
                                end
                            end else if (link_error) begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                    1'b1, sdspi_pkg::ST_LINK);
                            end else if (rx_byte inside {8'h00, 8'h01}) begin
                                bytes_left_next = bytes_dec;
                                if (bytes_dec == 10'd0) begin
                                    phase_next = PH_IDLE;
                                    push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b1,
                                                        rx_byte, 1'b1, sdspi_pkg::ST_OK);
                                end else begin
                                    phase_next = PH_RESP_EXTRA;
                                    push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b1,
                                                        rx_byte, 1'b0, sdspi_pkg::ST_OK);
                                end
                            end else begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b1, rx_byte,
                                                    1'b1, sdspi_pkg::ST_RESP);
                            end
                        end
                        PH_RESP_EXTRA: begin
                            push            = 1'b1;
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 10'd0) begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b1, rx_byte,
                                                    1'b1, sdspi_pkg::ST_OK);
                            end else begin
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b1, rx_byte,
                                                    1'b0, sdspi_pkg::ST_OK);
                            end
                        end
                        PH_RD_FLUSH: begin
                            phase_next      = PH_RD_R1;
                            poll_count_next = 16'd1;
                            push            = 1'b1;
                            push_job        = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                     1'b0, sdspi_pkg::ST_OK);
                        end
                        PH_RD_R1: begin
                            push = 1'b1;
                            if (link_error) begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                    1'b1, sdspi_pkg::ST_LINK);
                            end else if (rx_byte[7]) begin
                                if (limit_hit) begin
                                    phase_next = PH_IDLE;
                                    push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                        8'h00, 1'b1, sdspi_pkg::ST_TIMEOUT);
                                end else begin
                                    poll_count_next = poll_inc;
                                    push_job        = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                             8'h00, 1'b0, sdspi_pkg::ST_OK);
                                end
                            end else if (rx_byte == 8'h00) begin
                                phase_next      = PH_RD_TOKEN;
                                poll_count_next = 16'd1;
                                push_job        = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                         8'h00, 1'b0, sdspi_pkg::ST_OK);
                            end else begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                    1'b1, sdspi_pkg::ST_RESP);
                            end
                        end
                        PH_RD_TOKEN: begin
                            push = 1'b1;
                            if (link_error) begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                    1'b1, sdspi_pkg::ST_LINK);
                            end else if (rx_byte == sdspi_pkg::FILL_BYTE) begin
                                if (limit_hit) begin
                                    phase_next = PH_IDLE;
                                    push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                        8'h00, 1'b1, sdspi_pkg::ST_TIMEOUT);
                                end else begin
                                    poll_count_next = poll_inc;
                                    push_job        = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0,
                                                             8'h00, 1'b0, sdspi_pkg::ST_OK);
                                end
                            end else if (rx_byte == sdspi_pkg::DATA_TOKEN) begin
                                phase_next = PH_RD_DATA;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                    1'b0, sdspi_pkg::ST_OK);
                            end else begin
                                phase_next = PH_IDLE;
                                push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                    1'b1, sdspi_pkg::ST_TOKEN);
                            end
                        end
                        PH_RD_DATA: begin
                            push            = 1'b1;
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 10'd0) begin
                                phase_next = PH_RD_CRC1;
                            end
                            push_job = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b1, rx_byte,
                                              1'b0, sdspi_pkg::ST_OK);
                        end
                        PH_RD_CRC1: begin
                            phase_next = PH_RD_CRC2;
                            push       = 1'b1;
                            push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                1'b0, sdspi_pkg::ST_OK);
                        end
                        PH_RD_CRC2: begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            push_job   = single(1'b1, sdspi_pkg::FILL_BYTE, 1'b0, 8'h00,
                                                1'b1, sdspi_pkg::ST_OK);
                        end
                        default: begin
                            // Idle: a stray byte gives no result.
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    // Phase and counter registers, and the poll limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            poll_count_reg <= 16'd0;
            bytes_left_reg <= 10'd0;
            poll_limit_reg <= sdspi_pkg::POLL_LIMIT_RST;
        end else begin
            phase_reg      <= phase_next;
            poll_count_reg <= poll_count_next;
            bytes_left_reg <= bytes_left_next;
            if (cfg_we) begin
                poll_limit_reg <= cfg_wdata;
            end
        end
    end

endmodule

// File: hdl/sdspi_queue.sv
// Job queue between the front and the back part.
module sdspi_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sdspi_pkg::job_t      push_job,
    input  logic                 pop,
    output sdspi_pkg::job_t      head_job,
    output sdspi_pkg::q_status_t q_status
);

    sdspi_pkg::job_t                 entry_reg [sdspi_pkg::QDEPTH];
    logic [sdspi_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [sdspi_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [sdspi_pkg::QPTR_W:0]      count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_status.full  = (count_reg == (sdspi_pkg::QPTR_W + 1)'(sdspi_pkg::QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_job       = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    // Occupancy count.
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The front never pushes into a full queue, and the count stays in range.
    assert property (@(posedge aclk) disable iff (!aresetn) !(push && q_status.full))
        else $error("job pushed into a full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     count_reg <= (sdspi_pkg::QPTR_W + 1)'(sdspi_pkg::QDEPTH))
        else $error("queue count out of range");

endmodule

// File: hdl/sdspi_back.sv
// Back part: expands queued jobs into result transactions through an output register.
module sdspi_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdspi_pkg::job_t      head_job,
    input  sdspi_pkg::q_status_t q_status,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast
);

    logic [sdspi_pkg::BEAT_W-1:0] beat_reg, beat_next;
    logic                         m_tvalid_reg;
    logic [23:0]                  m_tdata_reg;
    logic                         m_tlast_reg;
    logic                         load;
    logic [7:0]                   frame_byte;
    logic [7:0]                   crc_byte;
    logic                         frame_end;
    logic [23:0]                  beat_data;

    assign load = !q_status.empty && (!m_tvalid_reg || m_tready);

    // Fixed CRC byte for the command index.
    always_comb begin
        if (head_job.frame_idx == sdspi_pkg::IDX_CMD0) begin
            crc_byte = sdspi_pkg::CRC_CMD0;
        end else if (head_job.frame_idx == sdspi_pkg::IDX_CMD8) begin
            crc_byte = sdspi_pkg::CRC_CMD8;
        end else begin
            crc_byte = sdspi_pkg::CRC_OTHER;
        end
    end

    // Frame byte for the current beat, argument most significant byte first.
    always_comb begin
        case (beat_reg)
            3'd0:    frame_byte = {sdspi_pkg::FRAME_START, head_job.frame_idx};
            3'd1:    frame_byte = head_job.frame_arg[31:24];
            3'd2:    frame_byte = head_job.frame_arg[23:16];
            3'd3:    frame_byte = head_job.frame_arg[15:8];
            3'd4:    frame_byte = head_job.frame_arg[7:0];
            default: frame_byte = crc_byte;
        endcase
    end

    assign frame_end = (beat_reg == sdspi_pkg::BEAT_LAST);

    // Result item for this beat; tdata fields listed from the highest bit down.
    always_comb begin
        if (head_job.is_frame) begin
            beat_data = {2'b00,
                         sdspi_pkg::ST_OK,
                         frame_end && head_job.frame_status,
                         8'h00, 1'b0,
                         frame_byte, 1'b1};
        end else begin
            beat_data = {2'b00,
                         head_job.status, head_job.status_valid,
                         head_job.data_byte, head_job.data_valid,
                         head_job.tx_byte, head_job.tx_valid};
        end
    end

    // Beat counter and queue pop.
    always_comb begin
        beat_next = beat_reg;
        pop       = 1'b0;
        if (load) begin
            if (head_job.is_frame) begin
                if (frame_end) begin
                    beat_next = '0;
                    pop       = 1'b1;
                end else begin
                    beat_next = beat_reg + 1'b1;
                end
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            beat_reg <= beat_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= beat_data;
            m_tlast_reg <= !head_job.is_frame || frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A frame in progress keeps its job at the queue head, and the beat stays in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
                     (beat_reg != '0) |-> !q_status.empty)
        else $error("frame beat running without a queued job");
    assert property (@(posedge aclk) disable iff (!aresetn)
                     beat_reg <= sdspi_pkg::BEAT_LAST)
        else $error("frame beat counter out of range");

endmodule

// File: hdl/sd_spi_command_response_engine.sv
// Top level of the SD SPI command and response engine: front, job queue and back.
//
//  Channel   Direction  Transaction when         Payload
//  s_*       in         s_tvalid && s_tready     tuser: cmd; tdata: request or card byte
//  m_*       out        m_tvalid && m_tready     tdata: tx, data and status; tlast: last
//  cfg_*     in         cfg_we                   cfg_wdata: poll limit
//
// An input transaction is taken in every cycle while the four-entry job queue has room.
// Each input yields at most one queue job; in the back a command frame job expands into one
// output transaction per frame byte and any other job into a single one, so the output side
// sets the sustained rate. Output results are registered from the job at the queue head.
// Reset (aresetn low, synchronous) clears the phase, the counters and the queue, and loads
// a poll limit of 256. A stalled output holds its register while the queue keeps filling.
module sd_spi_command_response_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command_index[7:0], argument[39:8], byte_count[49:40], rx_byte[57:50],
    // link_error[58], zero fill[63:59]
    input  logic [63:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tx_valid[0], tx_byte[8:1], data_valid[9], data_byte[17:10], status_valid[18],
    // status[21:19], zero fill[23:22]
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    sdspi_pkg::job_t      push_job;
    sdspi_pkg::job_t      head_job;
    sdspi_pkg::q_status_t q_status;
    logic                 push;
    logic                 pop;

    sdspi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    sdspi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    sdspi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
